// ----- rtl/tauv_pkg.sv -----
// shared types and constants for the tile atlas uv lookup block
package tauv_pkg;

    localparam int TW_W   = 13;
    localparam int IW_W   = 15;
    localparam int MRG_W  = 10;
    localparam int ID_W   = 29;
    localparam int COL_W  = 16;
    localparam int PITCH_W = 14;
    localparam int POS_W  = 16;
    localparam int UV_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_MARGIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_GAP      = 3'd5;

    localparam logic [TW_W-1:0]  TILE_SIZE_RESET  = 13'd16;
    localparam logic [IW_W-1:0]  IMAGE_SIZE_RESET = 15'd256;
    localparam logic [MRG_W-1:0] MARGIN_RESET     = 10'd0;
    localparam logic [COL_W-1:0] COLS_RESET       = 16'd16;

    typedef struct packed {
        logic bad;
        logic fh;
        logic fv;
        logic fd;
    } flags_t;

    typedef struct packed {
        logic [TW_W-1:0]  tile_width;
        logic [TW_W-1:0]  tile_height;
        logic [IW_W-1:0]  image_width;
        logic [IW_W-1:0]  image_height;
        logic [MRG_W-1:0] border_margin;
        logic [MRG_W-1:0] tile_gap;
    } geom_cfg_t;

endpackage

// ----- rtl/tile_atlas_uv_lookup_top.sv -----
// top level of the tile atlas uv lookup block
//
// usage: each request on the s_ group carries a tile id, the atlas first id
// and three flip flags; the block returns one result on the m_ group with
// the four corner texture coordinates in unsigned 1.FRAC_BITS and a bad
// tile flag. the cfg_ channel writes the six atlas geometry registers and
// is always ready; the user must use it only while no request is in flight,
// which the block itself does not enforce. the pipeline has one input
// stage, a 29-stage divider for row and column, three stages of multiply,
// offset and clamp, FRAC_BITS + 2 stages of uv division and one output
// stage. throughput is one request per cycle, set by the fully pipelined
// dividers, while no column recompute runs. after each register write the
// column count is recomputed by a bit-serial divider and s_tready stays
// low until it is done. reset loads the register defaults (16x16 tiles in
// a 256x256 atlas) and empties the pipeline. when the receiver stalls, the
// whole pipeline holds and s_tready drops; nothing is lost or repeated.
module tile_atlas_uv_lookup_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // tile_gid, first_id, zero pad
    input  logic [2:0]   s_tuser,   // flip_h, flip_v, flip_d
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // tl_u, tl_v, tr_u, tr_v, bl_u, bl_v, br_u, br_v
    output logic [0:0]   m_tuser,   // bad_tile
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [tauv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tauv_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int QW  = FRAC_BITS + 2;
    localparam int UVW = tauv_pkg::UV_W;
    localparam int DW  = tauv_pkg::IW_W;

    tauv_pkg::geom_cfg_t cfg_reg;
    logic                cfg_wr;
    logic [tauv_pkg::COL_W-1:0] cols;
    logic                cols_busy;
    logic                adv;

    logic                         s0_valid_reg;
    logic [tauv_pkg::ID_W-1:0]    s0_tile_reg;
    tauv_pkg::flags_t             s0_flags_reg;
    tauv_pkg::flags_t             in_flags;
    logic [tauv_pkg::ID_W-1:0]    gid, first;

    logic                         d_valid;
    logic [tauv_pkg::ID_W-1:0]    d_row;
    logic [tauv_pkg::COL_W-1:0]   d_col;
    logic [3:0]                   d_side;

    logic                         g_valid;
    tauv_pkg::flags_t             g_flags;
    logic [tauv_pkg::POS_W-1:0]   px_l, px_r, py_t, py_b;
    logic                         zero_w, zero_h;

    logic                         lu_valid;
    logic [QW-1:0]                lu_q, ru_q, tv_q, bv_q;
    logic [DW-1:0]                lu_r, ru_r, tv_r, bv_r;
    logic [4:0]                   lu_side;
    logic [0:0]                   ru_side, tv_side, bv_side;
    logic                         ru_valid, tv_valid, bv_valid;
    tauv_pkg::flags_t             f_flags;

    logic [UVW-1:0] lu, ru, tv, bv, tmp;
    logic [UVW-1:0] tl_u, tl_v, tr_u, tr_v, bl_u, bl_v, br_u, br_v;

    logic           out_valid_reg;
    logic [135:0]   out_data_reg;
    logic           out_bad_reg;

    function automatic logic [UVW-1:0] fix_out(input logic [QW-1:0] q, input logic zero);
        logic [QW-1:0] s;
        s = q;
        if (q[QW-1] || zero)
        begin
            s = {1'b0, {(QW-1){1'b1}}};
        end
        return UVW'(s);
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_width    <= tauv_pkg::TILE_SIZE_RESET;
            cfg_reg.tile_height   <= tauv_pkg::TILE_SIZE_RESET;
            cfg_reg.image_width   <= tauv_pkg::IMAGE_SIZE_RESET;
            cfg_reg.image_height  <= tauv_pkg::IMAGE_SIZE_RESET;
            cfg_reg.border_margin <= tauv_pkg::MARGIN_RESET;
            cfg_reg.tile_gap      <= tauv_pkg::MARGIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                tauv_pkg::REG_TILE_WIDTH:    cfg_reg.tile_width    <= cfg_data[tauv_pkg::TW_W-1:0];
                tauv_pkg::REG_TILE_HEIGHT:   cfg_reg.tile_height   <= cfg_data[tauv_pkg::TW_W-1:0];
                tauv_pkg::REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[tauv_pkg::IW_W-1:0];
                tauv_pkg::REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data[tauv_pkg::IW_W-1:0];
                tauv_pkg::REG_BORDER_MARGIN: cfg_reg.border_margin <= cfg_data[tauv_pkg::MRG_W-1:0];
                tauv_pkg::REG_TILE_GAP:      cfg_reg.tile_gap      <= cfg_data[tauv_pkg::MRG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tauv_cols u_cols (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cfg_wr),
        .cfg   (cfg_reg),
        .cols  (cols),
        .busy  (cols_busy)
    );

    // pipeline advance
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && !cols_busy;

    // input stage
    assign gid         = s_tdata[28:0];
    assign first       = s_tdata[57:29];
    assign in_flags.bad = (gid < first) || (cols == '0);
    assign in_flags.fh = s_tuser[0];
    assign in_flags.fv = s_tuser[1];
    assign in_flags.fd = s_tuser[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_tile_reg  <= gid - first;
            s0_flags_reg <= in_flags;
        end
    end

    // row and column
    tauv_div_pipe #(.QW(tauv_pkg::ID_W), .DW(tauv_pkg::COL_W), .SW(4)) u_div_rc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s0_valid_reg),
        .in_rem    ('0),
        .in_num    (s0_tile_reg),
        .in_den    (cols),
        .in_side   (s0_flags_reg),
        .out_valid (d_valid),
        .out_quo   (d_row),
        .out_rem   (d_col),
        .out_side  (d_side)
    );

    tauv_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .cfg       (cfg_reg),
        .in_valid  (d_valid),
        .row       (d_row),
        .col       (d_col),
        .in_flags  (tauv_pkg::flags_t'(d_side)),
        .out_valid (g_valid),
        .out_flags (g_flags),
        .px_l      (px_l),
        .px_r      (px_r),
        .py_t      (py_t),
        .py_b      (py_b)
    );

    assign zero_w = cfg_reg.image_width == '0;
    assign zero_h = cfg_reg.image_height == '0;

    // pixel to fixed point
    tauv_div_pipe #(.QW(QW), .DW(DW), .SW(5)) u_div_lu (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (g_valid),
        .in_rem ({1'b0, px_l[tauv_pkg::POS_W-1:2]}),
        .in_num ({px_l[1:0], {FRAC_BITS{1'b0}}}),
        .in_den (cfg_reg.image_width), .in_side ({g_flags, zero_w}),
        .out_valid (lu_valid), .out_quo (lu_q), .out_rem (lu_r), .out_side (lu_side)
    );

    tauv_div_pipe #(.QW(QW), .DW(DW), .SW(1)) u_div_ru (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (g_valid),
        .in_rem ({1'b0, px_r[tauv_pkg::POS_W-1:2]}),
        .in_num ({px_r[1:0], {FRAC_BITS{1'b0}}}),
        .in_den (cfg_reg.image_width), .in_side (zero_w),
        .out_valid (ru_valid), .out_quo (ru_q), .out_rem (ru_r), .out_side (ru_side)
    );

    tauv_div_pipe #(.QW(QW), .DW(DW), .SW(1)) u_div_tv (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (g_valid),
        .in_rem ({1'b0, py_t[tauv_pkg::POS_W-1:2]}),
        .in_num ({py_t[1:0], {FRAC_BITS{1'b0}}}),
        .in_den (cfg_reg.image_height), .in_side (zero_h),
        .out_valid (tv_valid), .out_quo (tv_q), .out_rem (tv_r), .out_side (tv_side)
    );

    tauv_div_pipe #(.QW(QW), .DW(DW), .SW(1)) u_div_bv (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (g_valid),
        .in_rem ({1'b0, py_b[tauv_pkg::POS_W-1:2]}),
        .in_num ({py_b[1:0], {FRAC_BITS{1'b0}}}),
        .in_den (cfg_reg.image_height), .in_side (zero_h),
        .out_valid (bv_valid), .out_quo (bv_q), .out_rem (bv_r), .out_side (bv_side)
    );

    // saturate and flip
    assign f_flags = tauv_pkg::flags_t'(lu_side[4:1]);

    always_comb
    begin
        lu = fix_out(lu_q, lu_side[0]);
        ru = fix_out(ru_q, ru_side[0]);
        tv = fix_out(tv_q, tv_side[0]);
        bv = fix_out(bv_q, bv_side[0]);
        if (f_flags.fh)
        begin
            tmp = lu; lu = ru; ru = tmp;
        end
        if (f_flags.fv)
        begin
            tmp = tv; tv = bv; bv = tmp;
        end
        tl_u = lu; tl_v = tv;
        tr_u = ru; tr_v = tv;
        bl_u = lu; bl_v = bv;
        br_u = ru; br_v = bv;
        if (f_flags.fd)
        begin
            tl_u = ru; tl_v = bv;
            br_u = lu; br_v = tv;
        end
        tmp = UVW'(lu_r ^ ru_r ^ tv_r ^ bv_r) & '0;
        if (f_flags.bad)
        begin
            tl_u = tmp; tl_v = tmp; tr_u = tmp; tr_v = tmp;
            bl_u = tmp; bl_v = tmp; br_u = tmp; br_v = tmp;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= lu_valid && ru_valid && tv_valid && bv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {br_v, br_u, bl_v, bl_u, tr_v, tr_u, tl_v, tl_u};
            out_bad_reg  <= f_flags.bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

endmodule

// ----- rtl/tauv_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage, with sideband
module tauv_div_pipe #(
    parameter int QW = 29,
    parameter int DW = 15,
    parameter int SW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_rem,
    output logic [SW-1:0] out_side
);

    logic          v_s   [0:QW];
    logic [DW-1:0] rem_s [0:QW];
    logic [QW-1:0] num_s [0:QW];
    logic [QW-1:0] quo_s [0:QW];
    logic [DW-1:0] den_s [0:QW];
    logic [SW-1:0] side_s [0:QW];

    assign v_s[0]    = in_valid;
    assign rem_s[0]  = in_rem;
    assign num_s[0]  = in_num;
    assign quo_s[0]  = '0;
    assign den_s[0]  = in_den;
    assign side_s[0] = in_side;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_s[k], num_s[k][QW-1]};
            diff     = trial - {1'b0, den_s[k]};
            ge       = trial >= {1'b0, den_s[k]};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_s[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_s[k+1] <= v_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_s[k+1]  <= rem_next;
                num_s[k+1]  <= num_s[k] << 1;
                quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
                den_s[k+1]  <= den_s[k];
                side_s[k+1] <= side_s[k];
            end
        end
    end

    assign out_valid = v_s[QW];
    assign out_quo   = quo_s[QW];
    assign out_rem   = rem_s[QW];
    assign out_side  = side_s[QW];

endmodule

// ----- rtl/tauv_geom.sv -----
// pixel positions of a tile's edges from its column and row, clamped per axis
module tauv_geom (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  tauv_pkg::geom_cfg_t            cfg,
    input  logic                           in_valid,
    input  logic [tauv_pkg::ID_W-1:0]      row,
    input  logic [tauv_pkg::COL_W-1:0]     col,
    input  tauv_pkg::flags_t               in_flags,
    output logic                           out_valid,
    output tauv_pkg::flags_t               out_flags,
    output logic [tauv_pkg::POS_W-1:0]     px_l,
    output logic [tauv_pkg::POS_W-1:0]     px_r,
    output logic [tauv_pkg::POS_W-1:0]     py_t,
    output logic [tauv_pkg::POS_W-1:0]     py_b
);

    localparam int PXW = tauv_pkg::COL_W + tauv_pkg::PITCH_W + 1;
    localparam int PYW = tauv_pkg::ID_W + tauv_pkg::PITCH_W + 1;

    logic [tauv_pkg::PITCH_W-1:0] pitch_x;
    logic [tauv_pkg::PITCH_W-1:0] pitch_y;
    logic [tauv_pkg::POS_W-1:0]   lim_x;
    logic [tauv_pkg::POS_W-1:0]   lim_y;

    logic [2:0]           v_reg;
    tauv_pkg::flags_t     f1_reg, f2_reg, f3_reg;
    logic [PXW-2:0]       prodx_reg;
    logic [PYW-2:0]       prody_reg;
    logic [PXW-1:0]       xl_reg, xr_reg;
    logic [PYW-1:0]       yt_reg, yb_reg;
    logic [tauv_pkg::POS_W-1:0] pxl_reg, pxr_reg, pyt_reg, pyb_reg;

    assign pitch_x = tauv_pkg::PITCH_W'(cfg.tile_width) + tauv_pkg::PITCH_W'(cfg.tile_gap);
    assign pitch_y = tauv_pkg::PITCH_W'(cfg.tile_height) + tauv_pkg::PITCH_W'(cfg.tile_gap);
    assign lim_x   = {cfg.image_width, 1'b0};
    assign lim_y   = {cfg.image_height, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // multiply
            prodx_reg <= (PXW-1)'(col) * (PXW-1)'(pitch_x);
            prody_reg <= (PYW-1)'(row) * (PYW-1)'(pitch_y);
            f1_reg    <= in_flags;
            // offsets
            xl_reg <= PXW'(prodx_reg) + PXW'(cfg.border_margin);
            xr_reg <= PXW'(prodx_reg) + PXW'(cfg.border_margin) + PXW'(cfg.tile_width);
            yt_reg <= PYW'(prody_reg) + PYW'(cfg.border_margin);
            yb_reg <= PYW'(prody_reg) + PYW'(cfg.border_margin) + PYW'(cfg.tile_height);
            f2_reg <= f1_reg;
            // clamp to twice the image size
            pxl_reg <= (xl_reg > PXW'(lim_x)) ? lim_x : xl_reg[tauv_pkg::POS_W-1:0];
            pxr_reg <= (xr_reg > PXW'(lim_x)) ? lim_x : xr_reg[tauv_pkg::POS_W-1:0];
            pyt_reg <= (yt_reg > PYW'(lim_y)) ? lim_y : yt_reg[tauv_pkg::POS_W-1:0];
            pyb_reg <= (yb_reg > PYW'(lim_y)) ? lim_y : yb_reg[tauv_pkg::POS_W-1:0];
            f3_reg  <= f2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign out_flags = f3_reg;
    assign px_l = pxl_reg;
    assign px_r = pxr_reg;
    assign py_t = pyt_reg;
    assign py_b = pyb_reg;

endmodule

// ----- rtl/tauv_cols.sv -----
// atlas column count, recomputed bit-serially after each register write
module tauv_cols (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr,
    input  tauv_pkg::geom_cfg_t         cfg,
    output logic [tauv_pkg::COL_W-1:0]  cols,
    output logic                        busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam int CNT_W = $clog2(tauv_pkg::COL_W + 1);

    logic [1:0]                      state_reg, state_next;
    logic [tauv_pkg::COL_W-1:0]      dvd_reg, dvd_next;
    logic [tauv_pkg::PITCH_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [tauv_pkg::COL_W-1:0]      cols_reg, cols_next;

    logic [tauv_pkg::COL_W:0]        numer;
    logic [tauv_pkg::COL_W:0]        span;
    logic [tauv_pkg::PITCH_W-1:0]    pitch;
    logic [tauv_pkg::PITCH_W:0]      trial;
    logic                            ge;

    assign numer = (tauv_pkg::COL_W+1)'(cfg.image_width) + (tauv_pkg::COL_W+1)'(cfg.tile_gap);
    assign span  = numer - (tauv_pkg::COL_W+1)'(cfg.border_margin);
    assign pitch = tauv_pkg::PITCH_W'(cfg.tile_width) + tauv_pkg::PITCH_W'(cfg.tile_gap);
    assign trial = {rem_reg, dvd_reg[tauv_pkg::COL_W-1]};
    assign ge    = trial >= {1'b0, pitch};

    always_comb
    begin
        state_next = state_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        cols_next  = cols_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (numer < (tauv_pkg::COL_W+1)'(cfg.border_margin) || pitch == '0)
                begin
                    cols_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    dvd_next   = span[tauv_pkg::COL_W-1:0];
                    rem_next   = '0;
                    cnt_next   = CNT_W'(tauv_pkg::COL_W);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rem_next = ge ? tauv_pkg::PITCH_W'(trial - {1'b0, pitch})
                              : trial[tauv_pkg::PITCH_W-1:0];
                dvd_next = {dvd_reg[tauv_pkg::COL_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    cols_next  = {dvd_reg[tauv_pkg::COL_W-2:0], ge};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (wr)
        begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cols_reg  <= tauv_pkg::COLS_RESET;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cols_reg  <= cols_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign cols = cols_reg;
    assign busy = state_reg != ST_IDLE;

endmodule

// ----- rtl/tauv_checker.sv -----
// port-level checks for the tile atlas uv lookup block
module tauv_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic [0:0]   m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("bad tile with nonzero coordinates");

    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("request taken during column recompute");

    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while pipeline stalled");

endmodule

bind tile_atlas_uv_lookup_top tauv_checker u_tauv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ----- tb/tb_tile_atlas_uv_lookup_top.sv -----
// testbench for the tile atlas uv lookup block: directed table, random requests, uv predictor
`timescale 1ns / 100ps

module tb_tile_atlas_uv_lookup_top;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 36;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int UVW = tauv_pkg::UV_W;
    localparam int IDW = tauv_pkg::ID_W;
    localparam int DATW = tauv_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [UVW-1:0] tl_u, tl_v, tr_u, tr_v, bl_u, bl_v, br_u, br_v;
        logic           bad;
    } uv_result_t;

    typedef struct {
        logic [IDW-1:0] gid;
        logic [IDW-1:0] first;
        logic [2:0]     flips;
        bit             typed;
        uv_result_t     fixed_result;
    } lookup_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [tauv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATW-1:0] cfg_data = '0;

    tauv_pkg::geom_cfg_t geom;
    uv_result_t expected_uv[$];
    int errors = 0;
    int idle_cycles = 0;
    int out_wait = 0;
    lookup_row_t rows[$];

    tile_atlas_uv_lookup_top #(.FRAC_BITS(FRAC)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] uv_fix(logic [63:0] px, logic [63:0] size);
        logic [63:0] q;
        logic [63:0] sat;
        sat = (64'd2 << FRAC) - 64'd1;
        if (size == 0)
            return sat;
        if (px > 64'd2 * size)
            px = 64'd2 * size;
        q = (px << FRAC) / size;
        return (q > sat) ? sat : q;
    endfunction

    function automatic uv_result_t predict_uv(logic [IDW-1:0] gid, logic [IDW-1:0] first,
                                              logic [2:0] flips);
        uv_result_t r;
        logic [63:0] pitch_x, pitch_y, numer, cols, tnum, px, py, lu, ru, tv, bv, t;
        pitch_x = 64'(geom.tile_width) + 64'(geom.tile_gap);
        pitch_y = 64'(geom.tile_height) + 64'(geom.tile_gap);
        numer = 64'(geom.image_width) + 64'(geom.tile_gap);
        cols = 0;
        r = '0;
        if (numer >= 64'(geom.border_margin) && pitch_x != 0)
            cols = (numer - 64'(geom.border_margin)) / pitch_x;
        if (gid < first || cols == 0)
        begin
            r.bad = 1'b1;
            return r;
        end
        tnum = 64'(gid) - 64'(first);
        px = 64'(geom.border_margin) + (tnum % cols) * pitch_x;
        py = 64'(geom.border_margin) + (tnum / cols) * pitch_y;
        lu = uv_fix(px, 64'(geom.image_width));
        ru = uv_fix(px + 64'(geom.tile_width), 64'(geom.image_width));
        tv = uv_fix(py, 64'(geom.image_height));
        bv = uv_fix(py + 64'(geom.tile_height), 64'(geom.image_height));
        if (flips[0])
        begin
            t = lu; lu = ru; ru = t;
        end
        if (flips[1])
        begin
            t = tv; tv = bv; bv = t;
        end
        r.tl_u = lu[UVW-1:0]; r.tl_v = tv[UVW-1:0];
        r.tr_u = ru[UVW-1:0]; r.tr_v = tv[UVW-1:0];
        r.bl_u = lu[UVW-1:0]; r.bl_v = bv[UVW-1:0];
        r.br_u = ru[UVW-1:0]; r.br_v = bv[UVW-1:0];
        if (flips[2])
        begin
            r.tl_u = ru[UVW-1:0]; r.tl_v = bv[UVW-1:0];
            r.br_u = lu[UVW-1:0]; r.br_v = tv[UVW-1:0];
        end
        return r;
    endfunction

    task automatic idle_clocks(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic write_reg(logic [tauv_pkg::CFG_IDX_W-1:0] idx, logic [DATW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        unique case (idx)
            tauv_pkg::REG_TILE_WIDTH:    geom.tile_width = val[tauv_pkg::TW_W-1:0];
            tauv_pkg::REG_TILE_HEIGHT:   geom.tile_height = val[tauv_pkg::TW_W-1:0];
            tauv_pkg::REG_IMAGE_WIDTH:   geom.image_width = val[tauv_pkg::IW_W-1:0];
            tauv_pkg::REG_IMAGE_HEIGHT:  geom.image_height = val[tauv_pkg::IW_W-1:0];
            tauv_pkg::REG_BORDER_MARGIN: geom.border_margin = val[tauv_pkg::MRG_W-1:0];
            tauv_pkg::REG_TILE_GAP:      geom.tile_gap = val[tauv_pkg::MRG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(int tw, int th, int iw, int ih, int mrg, int gap);
        s_tvalid <= 1'b0;
        wait (expected_uv.size() == 0);
        idle_clocks(LATENCY + 4);
        write_reg(tauv_pkg::REG_TILE_WIDTH, DATW'(tw));
        write_reg(tauv_pkg::REG_TILE_HEIGHT, DATW'(th));
        write_reg(tauv_pkg::REG_IMAGE_WIDTH, DATW'(iw));
        write_reg(tauv_pkg::REG_IMAGE_HEIGHT, DATW'(ih));
        write_reg(tauv_pkg::REG_BORDER_MARGIN, DATW'(mrg));
        write_reg(tauv_pkg::REG_TILE_GAP, DATW'(gap));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_lookup(logic [IDW-1:0] gid, logic [IDW-1:0] first, logic [2:0] flips,
                               bit typed, uv_result_t fixed_result);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            idle_clocks(gap);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, first, gid};
        s_tuser <= flips;
        do @(posedge clk); while (!s_tready);
        expected_uv.push_back(typed ? fixed_result : predict_uv(gid, first, flips));
    endtask

    task automatic add_row(logic [IDW-1:0] gid, logic [IDW-1:0] first, logic [2:0] flips,
                           bit typed, uv_result_t res);
        lookup_row_t row;
        row.gid = gid; row.first = first; row.flips = flips;
        row.typed = typed; row.fixed_result = res;
        rows.push_back(row);
    endtask

    task automatic random_lookup();
        logic [IDW-1:0] first, gid;
        first = ($urandom_range(0, 3) == 0) ? IDW'($urandom) : IDW'($urandom_range(0, 2000));
        case ($urandom_range(0, 5))
            0: gid = IDW'($urandom);
            1: gid = first - IDW'($urandom_range(1, 50));
            default: gid = first + IDW'($urandom_range(0, 600));
        endcase
        send_lookup(gid, first, 3'($urandom), 1'b0, '0);
    endtask

    // response side: per-result wait, compare with oldest expectation
    always @(posedge clk)
    begin
        uv_result_t got;
        uv_result_t want;
        int w;
        if (m_tvalid && m_tready)
        begin
            got = {m_tdata[16:0], m_tdata[33:17], m_tdata[50:34], m_tdata[67:51],
                   m_tdata[84:68], m_tdata[101:85], m_tdata[118:102], m_tdata[135:119],
                   m_tuser[0]};
            if (expected_uv.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end
            else
            begin
                want = expected_uv.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: uv mismatch expected %h actual %h", $time, want, got);
                end
            end
        end
        if (!rst_n)
        begin
            out_wait <= 0;
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            w = $urandom_range(0, 3);
            out_wait <= w;
            m_tready <= (w == 0);
        end
        else if (out_wait > 0)
        begin
            out_wait <= out_wait - 1;
            m_tready <= (out_wait == 1);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        uv_result_t bad_res;
        uv_result_t r0;
        int n;
        bad_res = '0;
        bad_res.bad = 1'b1;
        r0 = '0;
        r0.tr_u = 17'd4096; r0.br_u = 17'd4096; r0.bl_v = 17'd4096; r0.br_v = 17'd4096;
        geom.tile_width = tauv_pkg::TILE_SIZE_RESET;
        geom.tile_height = tauv_pkg::TILE_SIZE_RESET;
        geom.image_width = tauv_pkg::IMAGE_SIZE_RESET;
        geom.image_height = tauv_pkg::IMAGE_SIZE_RESET;
        geom.border_margin = tauv_pkg::MARGIN_RESET;
        geom.tile_gap = tauv_pkg::MARGIN_RESET;
        idle_clocks(4);
        rst_n <= 1'b1;
        idle_clocks(20);

        // directed rows at reset geometry
        add_row(0, 0, 3'b000, 1'b1, r0);
        add_row(5, 6, 3'b000, 1'b1, bad_res);
        add_row(0, 29'h1FFFFFFF, 3'b111, 1'b1, bad_res);
        add_row(29'h1FFFFFFF, 0, 3'b000, 1'b0, '0);
        add_row(29'h1FFFFFFF, 29'h1FFFFFFF, 3'b111, 1'b0, '0);
        add_row(17, 0, 3'b001, 1'b0, '0);
        add_row(17, 0, 3'b010, 1'b0, '0);
        add_row(17, 0, 3'b100, 1'b0, '0);
        add_row(255, 0, 3'b011, 1'b0, '0);
        add_row(256, 0, 3'b101, 1'b0, '0);
        add_row(29'h15555555, 29'h0AAAAAAA, 3'b110, 1'b0, '0);
        foreach (rows[i])
            send_lookup(rows[i].gid, rows[i].first, rows[i].flips,
                        rows[i].typed, rows[i].fixed_result);

        // column count zero from a margin past the image
        set_geometry(16, 16, 100, 100, 1023, 0);
        send_lookup(3, 0, 3'b000, 1'b1, bad_res);
        // image size zero, with zero-width tiles and with one-pixel tiles
        set_geometry(0, 0, 0, 0, 0, 0);
        send_lookup(3, 0, 3'b000, 1'b1, bad_res);
        set_geometry(1, 1, 0, 0, 0, 1);
        send_lookup(0, 0, 3'b000, 1'b1, bad_res);
        // extremes
        set_geometry(4096, 4096, 16384, 16384, 1023, 1023);
        send_lookup(2, 0, 3'b111, 1'b0, '0);
        send_lookup(1000, 0, 3'b000, 1'b0, '0);
        set_geometry(8191, 8191, 32767, 32767, 0, 0);
        send_lookup(7, 3, 3'b101, 1'b0, '0);
        set_geometry(0, 0, 32767, 32767, 0, 1);
        send_lookup(29'h1FFFFFFF, 0, 3'b000, 1'b0, '0);
        send_lookup(32767, 0, 3'b011, 1'b0, '0);
        set_geometry(1, 1, 1, 1, 0, 0);
        send_lookup(1, 0, 3'b000, 1'b0, '0);
        send_lookup(0, 0, 3'b111, 1'b0, '0);

        // random phases, the first at the reset geometry and the rest over random geometries
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 0)
                set_geometry(16, 16, 256, 256, 0, 0);
            else
                set_geometry($urandom_range(1, 64), $urandom_range(1, 64),
                             $urandom_range(1, 1024), $urandom_range(1, 1024),
                             $urandom_range(0, 40), $urandom_range(0, 8));
            n = (ph % 3 == 0) ? 20 : 150;
            for (int i = 0; i < n; i++)
                random_lookup();
        end
        set_geometry(int'(13'($urandom)), int'(13'($urandom)), int'(15'($urandom)),
                     int'(15'($urandom)), int'(10'($urandom)), int'(10'($urandom)));
        for (int i = 0; i < 250; i++)
            random_lookup();

        s_tvalid <= 1'b0;
        wait (expected_uv.size() == 0);
        idle_clocks(LATENCY + 10);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
